### src/cartesian_to_spherical_top_assert.svh
// Assertion macros shared by the cartesian to spherical converter.
// Each macro expands to a concurrent assertion, or to nothing in synthesis.
`ifndef CARTESIAN_TO_SPHERICAL_TOP_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define C2S_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define C2S_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define C2S_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define C2S_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/c2s_pkg.sv
// Package of the cartesian to spherical converter: widths, constants and step functions.
// Used by every module of the block; depends on nothing.
package c2s_pkg;

    // Input coordinate width and the fraction bits that bring it to a 32-bit scale.
    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 32 - COORD_WIDTH;

    // Squares and the square-root pipeline.
    localparam int SQ_W      = 2 * COORD_WIDTH;
    localparam int SQ_IN_W   = (2 * COORD_WIDTH + 4 > 64) ? 2 * COORD_WIDTH + 4 : 64;
    localparam int ROOT_W    = SQ_IN_W / 2;
    localparam int REM_W     = ROOT_W + 2;

    // CORDIC operands, datapath and angle accumulator (radians, Q32).
    localparam int CORDIC_STEPS = 32;
    localparam int CS_IDX_W     = $clog2(CORDIC_STEPS);
    localparam int OPD_W        = 35;
    localparam int PRESCALE     = 22;
    localparam int CORD_W       = 59;
    localparam int ANG_W        = 36;

    localparam logic signed [ANG_W-1:0] HALF_PI = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] PI_Q32  = 36'sd13493037704;

    // atan(2^-i) in radians, Q32, rounded to nearest.
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
        32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
        32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
        32'd1048576,    32'd524288,     32'd262144,     32'd131072,
        32'd65536,      32'd32768,      32'd16384,      32'd8192,
        32'd4096,       32'd2048,       32'd1024,       32'd512,
        32'd256,        32'd128,        32'd64,         32'd32,
        32'd16,         32'd8,          32'd4,          32'd2
    };

    // Radians Q32 to degrees Q8.8: times 14667776, divided by 1000 * 2^32, rounded.
    localparam int DEG_W      = 24;
    localparam int M_LO       = 18;
    localparam int SUM_W      = 60;
    localparam int T_W        = 27;
    localparam int K_W        = 27;
    localparam int Q_W        = 17;
    localparam int DIV_W      = 10;
    localparam int RES_W      = 17;
    localparam int RECIP_SH   = 36;
    localparam int DEG_STAGES = 6;
    localparam logic [DEG_W-1:0] DEG_NUM  = 24'd14667776;
    localparam logic [SUM_W-1:0] DEG_HALF = 60'd2147483648000;
    localparam logic [K_W-1:0]   RECIP_K  = 27'd68719476;
    localparam logic [DIV_W-1:0] DEG_DIV  = 10'd1000;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } c2s_sq_t;

    typedef struct packed {
        logic signed [OPD_W-1:0] opp;
        logic signed [OPD_W-1:0] adj;
    } c2s_vec_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] cx;
        logic signed [CORD_W-1:0] cy;
        logic signed [ANG_W-1:0]  ang;
    } c2s_lane_t;

    // One digit of the restoring square root.
    function automatic c2s_sq_t sqrt_step(input logic [REM_W-1:0] rem,
                                          input logic [ROOT_W-1:0] root,
                                          input logic [1:0] pair);
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        c2s_sq_t r;
        cur   = {rem[REM_W-3:0], pair};
        trial = {root, 2'b01};
        if (cur >= trial) begin
            r.rem  = cur - trial;
            r.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur;
            r.root = {root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Coordinate scaled to the 32-bit range and sign extended.
    function automatic logic signed [OPD_W-1:0] scale_coord(
            input logic signed [COORD_WIDTH-1:0] c);
        logic signed [OPD_W-1:0] r;
        r = OPD_W'(c);
        r = r <<< FRAC_BITS;
        return r;
    endfunction

    // Operand widened to the datapath and multiplied by 2^22.
    function automatic logic signed [CORD_W-1:0] widen(input logic signed [OPD_W-1:0] v);
        logic signed [CORD_W-1:0] r;
        r = CORD_W'(v);
        r = r <<< PRESCALE;
        return r;
    endfunction

    // Axis cases and the quarter turn into the right half plane.
    function automatic c2s_lane_t cordic_pre(input c2s_vec_t v);
        c2s_lane_t r;
        r.cx  = '0;
        r.cy  = '0;
        r.ang = '0;
        if (v.opp == '0) begin
            r.ang = v.adj[OPD_W-1] ? PI_Q32 : '0;
        end else if (v.adj == '0) begin
            r.ang = v.opp[OPD_W-1] ? -HALF_PI : HALF_PI;
        end else if (v.adj[OPD_W-1]) begin
            if (!v.opp[OPD_W-1]) begin
                r.cx  = widen(v.opp);
                r.cy  = widen(-v.adj);
                r.ang = HALF_PI;
            end else begin
                r.cx  = widen(-v.opp);
                r.cy  = widen(v.adj);
                r.ang = -HALF_PI;
            end
        end else begin
            r.cx = widen(v.adj);
            r.cy = widen(v.opp);
        end
        return r;
    endfunction

    // One vectoring rotation; a lane whose opposite side is zero has finished.
    function automatic c2s_lane_t cordic_iter(input c2s_lane_t s, input int i);
        logic signed [CORD_W-1:0] dx;
        logic signed [CORD_W-1:0] dy;
        logic signed [ANG_W-1:0]  da;
        c2s_lane_t r;
        dx = s.cy >>> i;
        dy = s.cx >>> i;
        da = $signed({{(ANG_W-32){1'b0}}, ATAN_TAB[i[CS_IDX_W-1:0]]});
        r  = s;
        if (s.cy != '0) begin
            if (!s.cy[CORD_W-1]) begin
                r.cx  = s.cx + dx;
                r.cy  = s.cy - dy;
                r.ang = s.ang + da;
            end else begin
                r.cx  = s.cx - dx;
                r.cy  = s.cy + dy;
                r.ang = s.ang - da;
            end
        end
        return r;
    endfunction

endpackage

### src/c2s_root.sv
// Two parallel square-root pipelines, one result digit per stage, with coordinates alongside.
// Depends on c2s_pkg.
module c2s_root (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 vld_in,
    input  logic [c2s_pkg::SQ_IN_W-1:0]          rad_rho,
    input  logic [c2s_pkg::SQ_IN_W-1:0]          rad_mag,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] x_in,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] y_in,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] z_in,
    output logic                                 vld_out,
    output logic [c2s_pkg::ROOT_W-1:0]           root_rho,
    output logic [c2s_pkg::ROOT_W-1:0]           root_mag,
    output logic signed [c2s_pkg::COORD_WIDTH-1:0] x_out,
    output logic signed [c2s_pkg::COORD_WIDTH-1:0] y_out,
    output logic signed [c2s_pkg::COORD_WIDTH-1:0] z_out
);
    import c2s_pkg::*;

    logic                          valid_reg [ROOT_W];
    logic [SQ_IN_W-1:0]            rad_reg   [ROOT_W][2];
    logic [REM_W-1:0]              rem_reg   [ROOT_W][2];
    logic [ROOT_W-1:0]             root_reg  [ROOT_W][2];
    logic signed [COORD_WIDTH-1:0] x_reg     [ROOT_W];
    logic signed [COORD_WIDTH-1:0] y_reg     [ROOT_W];
    logic signed [COORD_WIDTH-1:0] z_reg     [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic                          vld_src;
        logic [SQ_IN_W-1:0]            rad_src  [2];
        logic [REM_W-1:0]              rem_src  [2];
        logic [ROOT_W-1:0]             root_src [2];
        logic signed [COORD_WIDTH-1:0] x_src;
        logic signed [COORD_WIDTH-1:0] y_src;
        logic signed [COORD_WIDTH-1:0] z_src;
        c2s_sq_t                       sq_next  [2];

        // Stage input: the ports for the first digit, the previous stage after that.
        if (k == 0) begin : g_first
            assign vld_src     = vld_in;
            assign rad_src[0]  = rad_rho;
            assign rad_src[1]  = rad_mag;
            assign rem_src[0]  = '0;
            assign rem_src[1]  = '0;
            assign root_src[0] = '0;
            assign root_src[1] = '0;
            assign x_src       = x_in;
            assign y_src       = y_in;
            assign z_src       = z_in;
        end else begin : g_next
            assign vld_src     = valid_reg[k-1];
            assign rad_src[0]  = rad_reg[k-1][0];
            assign rad_src[1]  = rad_reg[k-1][1];
            assign rem_src[0]  = rem_reg[k-1][0];
            assign rem_src[1]  = rem_reg[k-1][1];
            assign root_src[0] = root_reg[k-1][0];
            assign root_src[1] = root_reg[k-1][1];
            assign x_src       = x_reg[k-1];
            assign y_src       = y_reg[k-1];
            assign z_src       = z_reg[k-1];
        end

        // Next root digit from the top two radicand bits of each lane.
        for (genvar l = 0; l < 2; l++) begin : g_lane
            assign sq_next[l] = sqrt_step(rem_src[l], root_src[l],
                                          rad_src[l][SQ_IN_W-1 -: 2]);
        end

        // Valid bit of the stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= vld_src;
            end
        end

        // Stage payload.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rad_reg[k][l]  <= rad_src[l] << 2;
                    rem_reg[k][l]  <= sq_next[l].rem;
                    root_reg[k][l] <= sq_next[l].root;
                end
                x_reg[k] <= x_src;
                y_reg[k] <= y_src;
                z_reg[k] <= z_src;
            end
        end
    end

    assign vld_out  = valid_reg[ROOT_W-1];
    assign root_rho = root_reg[ROOT_W-1][0];
    assign root_mag = root_reg[ROOT_W-1][1];
    assign x_out    = x_reg[ROOT_W-1];
    assign y_out    = y_reg[ROOT_W-1];
    assign z_out    = z_reg[ROOT_W-1];

endmodule

### src/c2s_cordic.sv
// Unrolled vectoring CORDIC for the polar and azimuth angles, one rotation per stage.
// Depends on c2s_pkg.
module c2s_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               vld_in,
    input  c2s_pkg::c2s_vec_t                  pol_vec,
    input  c2s_pkg::c2s_vec_t                  azi_vec,
    input  logic [c2s_pkg::COORD_WIDTH-1:0]    mag_in,
    output logic                               vld_out,
    output logic signed [c2s_pkg::ANG_W-1:0]   ang_pol,
    output logic signed [c2s_pkg::ANG_W-1:0]   ang_azi,
    output logic [c2s_pkg::COORD_WIDTH-1:0]    mag_out
);
    import c2s_pkg::*;

    logic                   pre_valid_reg;
    c2s_lane_t              pre_lane_reg [2];
    logic [COORD_WIDTH-1:0] pre_mag_reg;
    c2s_lane_t              pre_next     [2];

    logic                   valid_reg [CORDIC_STEPS];
    c2s_lane_t              lane_reg  [CORDIC_STEPS][2];
    logic [COORD_WIDTH-1:0] mag_reg   [CORDIC_STEPS];

    // Axis cases and quadrant folding before the rotations.
    assign pre_next[0] = cordic_pre(pol_vec);
    assign pre_next[1] = cordic_pre(azi_vec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_lane_reg[0] <= pre_next[0];
            pre_lane_reg[1] <= pre_next[1];
            pre_mag_reg     <= mag_in;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
        logic                   vld_src;
        c2s_lane_t              lane_src  [2];
        c2s_lane_t              lane_next [2];
        logic [COORD_WIDTH-1:0] mag_src;

        if (k == 0) begin : g_first
            assign vld_src     = pre_valid_reg;
            assign lane_src[0] = pre_lane_reg[0];
            assign lane_src[1] = pre_lane_reg[1];
            assign mag_src     = pre_mag_reg;
        end else begin : g_next
            assign vld_src     = valid_reg[k-1];
            assign lane_src[0] = lane_reg[k-1][0];
            assign lane_src[1] = lane_reg[k-1][1];
            assign mag_src     = mag_reg[k-1];
        end

        // Rotation by atan(2^-k) in both lanes.
        assign lane_next[0] = cordic_iter(lane_src[0], k);
        assign lane_next[1] = cordic_iter(lane_src[1], k);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lane_reg[k][0] <= lane_next[0];
                lane_reg[k][1] <= lane_next[1];
                mag_reg[k]     <= mag_src;
            end
        end
    end

    assign vld_out = valid_reg[CORDIC_STEPS-1];
    assign ang_pol = lane_reg[CORDIC_STEPS-1][0].ang;
    assign ang_azi = lane_reg[CORDIC_STEPS-1][1].ang;
    assign mag_out = mag_reg[CORDIC_STEPS-1];

endmodule

### src/c2s_deg.sv
// Radians Q32 to degrees Q8.8 for both angles, ending in the output registers.
// Depends on c2s_pkg.
module c2s_deg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               vld_in,
    input  logic signed [c2s_pkg::ANG_W-1:0]   ang_pol,
    input  logic signed [c2s_pkg::ANG_W-1:0]   ang_azi,
    input  logic [c2s_pkg::COORD_WIDTH-1:0]    mag_in,
    output logic                               vld_out,
    output logic [c2s_pkg::COORD_WIDTH-1:0]    magnitude,
    output logic [15:0]                        polar_angle,
    output logic signed [c2s_pkg::RES_W-1:0]   azimuth
);
    import c2s_pkg::*;

    localparam int M_W    = ANG_W - 1;
    localparam int PLO_W  = M_LO + DEG_W;
    localparam int PHI_W  = M_W - M_LO + DEG_W;
    localparam int PROD_W = Q_W + DIV_W;

    logic                   valid_reg [DEG_STAGES];
    logic [COORD_WIDTH-1:0] mag_reg   [DEG_STAGES];
    logic [1:0]             sign_reg  [DEG_STAGES];

    logic signed [ANG_W-1:0] ang_in    [2];
    logic [M_W-1:0]          m_next    [2];
    logic [M_W-1:0]          m_reg     [2];
    logic [PLO_W-1:0]        plo_next  [2];
    logic [PHI_W-1:0]        phi_next  [2];
    logic [PLO_W-1:0]        plo_reg   [2];
    logic [PHI_W-1:0]        phi_reg   [2];
    logic [SUM_W-1:0]        sum_next  [2];
    logic [T_W-1:0]          t2_reg    [2];
    logic [T_W-1:0]          t3_reg    [2];
    logic [T_W-1:0]          t4_reg    [2];
    logic [T_W+K_W-1:0]      qp_next   [2];
    logic [Q_W-1:0]          q0_reg    [2];
    logic [Q_W-1:0]          q0b_reg   [2];
    logic [PROD_W-1:0]       prod_next [2];
    logic [PROD_W-1:0]       prod_reg  [2];
    logic [T_W-1:0]          rem_next  [2];
    logic [Q_W-1:0]          q_next    [2];
    logic signed [RES_W-1:0] res_next  [2];
    logic signed [RES_W-1:0] res_reg   [2];
    logic [1:0]              sign_next;

    assign ang_in[0] = ang_pol;
    assign ang_in[1] = ang_azi;
    assign sign_next = {ang_azi[ANG_W-1], ang_pol[ANG_W-1]};

    // Datapath of each lane: magnitude, split product, rounding, divide by 1000, sign.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            m_next[l]    = ang_in[l][ANG_W-1] ? M_W'(-ang_in[l]) : ang_in[l][M_W-1:0];
            plo_next[l]  = m_reg[l][M_LO-1:0] * DEG_NUM;
            phi_next[l]  = m_reg[l][M_W-1:M_LO] * DEG_NUM;
            sum_next[l]  = SUM_W'({phi_reg[l], {M_LO{1'b0}}}) + SUM_W'(plo_reg[l]) + DEG_HALF;
            qp_next[l]   = t2_reg[l] * RECIP_K;
            prod_next[l] = q0_reg[l] * DEG_DIV;
            rem_next[l]  = t4_reg[l] - T_W'(prod_reg[l]);
            q_next[l]    = q0b_reg[l] + Q_W'(rem_next[l] >= T_W'(DEG_DIV));
            res_next[l]  = sign_reg[4][l] ? -$signed(RES_W'(q_next[l]))
                                          : $signed(RES_W'(q_next[l]));
        end
    end

    // Valid bits of the six stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEG_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= vld_in;
            for (int k = 1; k < DEG_STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0]  <= mag_in;
            sign_reg[0] <= sign_next;
            for (int k = 1; k < DEG_STAGES; k++)
            begin
                mag_reg[k]  <= mag_reg[k-1];
                sign_reg[k] <= sign_reg[k-1];
            end
            for (int l = 0; l < 2; l++)
            begin
                m_reg[l]    <= m_next[l];
                plo_reg[l]  <= plo_next[l];
                phi_reg[l]  <= phi_next[l];
                t2_reg[l]   <= sum_next[l][32 +: T_W];
                t3_reg[l]   <= t2_reg[l];
                q0_reg[l]   <= qp_next[l][RECIP_SH +: Q_W];
                t4_reg[l]   <= t3_reg[l];
                q0b_reg[l]  <= q0_reg[l];
                prod_reg[l] <= prod_next[l];
                res_reg[l]  <= res_next[l];
            end
        end
    end

    assign vld_out     = valid_reg[DEG_STAGES-1];
    assign magnitude   = mag_reg[DEG_STAGES-1];
    assign polar_angle = res_reg[0][15:0];
    assign azimuth     = res_reg[1];

endmodule

### src/cartesian_to_spherical_top.sv
// Cartesian to spherical converter: takes (x, y, z) and returns the rounded length, the polar
// angle and the azimuth in Q8.8 degrees. A new vector enters every clock cycle while the pipeline
// advances; it passes through the squaring and summing registers, 32 square-root digit stages,
// 1 folding stage and 32 CORDIC rotation stages, and 6 stages of degree scaling. All stages
// advance together; while a result waits at the output and out_ready is low the whole pipeline
// holds and in_ready is low. The zero vector gives length 0 and both angles 0.
// Depends on c2s_pkg, c2s_root, c2s_cordic, c2s_deg and the assertion macros.
`include "cartesian_to_spherical_top_assert.svh"

module cartesian_to_spherical_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] x,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] y,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [c2s_pkg::COORD_WIDTH-1:0]        magnitude,
    output logic [15:0]                            polar_angle,
    output logic signed [c2s_pkg::RES_W-1:0]       azimuth
);
    import c2s_pkg::*;

    logic                          adv;
    logic signed [SQ_W-1:0]        xx_s;
    logic signed [SQ_W-1:0]        yy_s;
    logic signed [SQ_W-1:0]        zz_s;

    logic                          a_valid_reg;
    logic [SQ_W-1:0]               xx_reg;
    logic [SQ_W-1:0]               yy_reg;
    logic [SQ_W-1:0]               zz_reg;
    logic signed [COORD_WIDTH-1:0] a_x_reg;
    logic signed [COORD_WIDTH-1:0] a_y_reg;
    logic signed [COORD_WIDTH-1:0] a_z_reg;

    logic                          b_valid_reg;
    logic [SQ_W:0]                 sxy_reg;
    logic [SQ_W+1:0]               s_reg;
    logic signed [COORD_WIDTH-1:0] b_x_reg;
    logic signed [COORD_WIDTH-1:0] b_y_reg;
    logic signed [COORD_WIDTH-1:0] b_z_reg;

    logic [SQ_IN_W-1:0]            rad_rho;
    logic [SQ_IN_W-1:0]            rad_mag;
    logic                          r_valid;
    logic [ROOT_W-1:0]             root_rho;
    logic [ROOT_W-1:0]             root_mag;
    logic signed [COORD_WIDTH-1:0] r_x;
    logic signed [COORD_WIDTH-1:0] r_y;
    logic signed [COORD_WIDTH-1:0] r_z;

    logic [ROOT_W:0]               mag_full;
    c2s_vec_t                      pol_vec;
    c2s_vec_t                      azi_vec;

    logic                          c_valid;
    logic signed [ANG_W-1:0]       ang_pol;
    logic signed [ANG_W-1:0]       ang_azi;
    logic [COORD_WIDTH-1:0]        c_mag;

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv      = out_ready || !out_valid;
    assign in_ready = adv;

    // Squares of the three coordinates.
    assign xx_s = x * x;
    assign yy_s = y * y;
    assign zz_s = z * z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Square and sum registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_reg  <= $unsigned(xx_s);
            yy_reg  <= $unsigned(yy_s);
            zz_reg  <= $unsigned(zz_s);
            a_x_reg <= x;
            a_y_reg <= y;
            a_z_reg <= z;
            sxy_reg <= (SQ_W+1)'(xx_reg) + (SQ_W+1)'(yy_reg);
            s_reg   <= (SQ_W+2)'(xx_reg) + (SQ_W+2)'(yy_reg) + (SQ_W+2)'(zz_reg);
            b_x_reg <= a_x_reg;
            b_y_reg <= a_y_reg;
            b_z_reg <= a_z_reg;
        end
    end

    // Radicands: rho at the 32-bit scale, the length with one extra bit for rounding.
    assign rad_rho = SQ_IN_W'(sxy_reg) << (2 * FRAC_BITS);
    assign rad_mag = SQ_IN_W'(s_reg) << 2;

    c2s_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (b_valid_reg),
        .rad_rho  (rad_rho),
        .rad_mag  (rad_mag),
        .x_in     (b_x_reg),
        .y_in     (b_y_reg),
        .z_in     (b_z_reg),
        .vld_out  (r_valid),
        .root_rho (root_rho),
        .root_mag (root_mag),
        .x_out    (r_x),
        .y_out    (r_y),
        .z_out    (r_z)
    );

    // Length rounded to nearest from the doubled root; CORDIC operand pairs.
    assign mag_full    = (ROOT_W+1)'(root_mag) + (ROOT_W+1)'(1);
    assign pol_vec.opp = $signed(OPD_W'(root_rho));
    assign pol_vec.adj = scale_coord(r_z);
    assign azi_vec.opp = scale_coord(r_y);
    assign azi_vec.adj = scale_coord(r_x);

    c2s_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (r_valid),
        .pol_vec (pol_vec),
        .azi_vec (azi_vec),
        .mag_in  (mag_full[COORD_WIDTH:1]),
        .vld_out (c_valid),
        .ang_pol (ang_pol),
        .ang_azi (ang_azi),
        .mag_out (c_mag)
    );

    c2s_deg u_deg (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .vld_in      (c_valid),
        .ang_pol     (ang_pol),
        .ang_azi     (ang_azi),
        .mag_in      (c_mag),
        .vld_out     (out_valid),
        .magnitude   (magnitude),
        .polar_angle (polar_angle),
        .azimuth     (azimuth)
    );

    // An accepted transaction always occupies the first stage on the next cycle.
    `C2S_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_valid && in_ready, a_valid_reg, "accepted transaction lost")
    // Polar angle lies between 0 and 180 degrees.
    `C2S_ASSERT_IMPLY(a_polar_range, clk, rst_n, out_valid, polar_angle <= 16'd46080, "polar angle out of range")
    // Azimuth lies between -180 and 180 degrees.
    `C2S_ASSERT_IMPLY(a_azim_range, clk, rst_n, out_valid, (azimuth <= 17'sd46080) && (azimuth >= -17'sd46080), "azimuth out of range")
    // A zero length only comes from the zero vector, whose angles are both zero.
    `C2S_ASSERT_IMPLY(a_zero_vector, clk, rst_n, out_valid && (magnitude == '0), (polar_angle == '0) && (azimuth == '0), "zero vector angles not zero")

endmodule

### sim/testbench.sv
// Self-checking testbench for the cartesian to spherical converter: directed, random and
// back-pressure transactions, checked against a bit-exact predictor held here.
// Depends on c2s_pkg and cartesian_to_spherical_top.
`timescale 1ns / 100ps

module testbench;

    localparam int CW = c2s_pkg::COORD_WIDTH;
    localparam int STEPS = 32;
    localparam longint unsigned DEG_SCALE = 64'd14667776;
    localparam longint unsigned DEG_DIVISOR = 64'd4294967296000;

    typedef struct {
        logic [CW-1:0]        mag;
        logic [15:0]          pol;
        logic signed [16:0]   azi;
    } sphere_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [CW-1:0] x = '0;
    logic signed [CW-1:0] y = '0;
    logic signed [CW-1:0] z = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CW-1:0]        magnitude;
    logic [15:0]          polar_angle;
    logic signed [16:0]   azimuth;

    sphere_t pending_results[$];
    longint  arctan_q32[STEPS];
    int      mismatches = 0;
    int      burst_left = 0;
    int      stall_pct = 30;
    int      hold_request = 0;
    int      hold_left = 0;

    cartesian_to_spherical_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .x(x), .y(y), .z(z),
        .out_valid(out_valid), .out_ready(out_ready),
        .magnitude(magnitude), .polar_angle(polar_angle), .azimuth(azimuth)
    );

    // Clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Arctangent of 1/n in Q62 by the alternating series.
    function automatic longint unsigned arctan_inv_q62(input longint unsigned n);
        longint unsigned p, nn, sum, k, term;
        p = (64'd1 << 62) / n;
        nn = n * n;
        sum = 0;
        k = 0;
        while (p != 0)
        begin
            term = p / (2 * k + 1);
            if (k[0] == 1'b0)
                sum = sum + term;
            else
                sum = sum - term;
            p = p / nn;
            k++;
        end
        return sum;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC angle of (adj, opp) in radians Q32.
    function automatic longint vector_angle(input longint opp, input longint adj);
        longint half_pi, ang, t, dx, dy;
        half_pi = 2 * arctan_q32[0];
        ang = 0;
        if (opp == 0)
            return (adj >= 0) ? 0 : 2 * half_pi;
        if (adj == 0)
            return (opp > 0) ? half_pi : -half_pi;
        if (adj < 0)
        begin
            t = adj;
            if (opp > 0)
            begin
                adj = opp;
                opp = -t;
                ang = half_pi;
            end
            else
            begin
                adj = -opp;
                opp = t;
                ang = -half_pi;
            end
        end
        adj = adj <<< 22;
        opp = opp <<< 22;
        for (int i = 0; i < STEPS; i++)
        begin
            if (opp == 0)
                break;
            dx = opp >>> i;
            dy = adj >>> i;
            if (opp > 0)
            begin
                adj = adj + dx;
                opp = opp - dy;
                ang = ang + arctan_q32[i];
            end
            else
            begin
                adj = adj - dx;
                opp = opp + dy;
                ang = ang - arctan_q32[i];
            end
        end
        return ang;
    endfunction

    // Radians Q32 to Q8.8 degrees, rounded half away from zero.
    function automatic longint degrees_q8(input longint a);
        longint unsigned m, q;
        m = (a < 0) ? -a : a;
        q = (m * DEG_SCALE + DEG_DIVISOR / 2) / DEG_DIVISOR;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic sphere_t predict_sphere(input logic signed [CW-1:0] px,
                                               input logic signed [CW-1:0] py,
                                               input logic signed [CW-1:0] pz);
        longint xi, yi, zi;
        longint unsigned sxy, s, n, rho;
        sphere_t r;
        xi = px;
        yi = py;
        zi = pz;
        sxy = xi * xi + yi * yi;
        s = sxy + zi * zi;
        n = int_sqrt(s);
        if (s > n * n + n)
            n++;
        rho = int_sqrt(sxy << (2 * (32 - CW)));
        r.mag = n[CW-1:0];
        r.pol = 16'(degrees_q8(vector_angle(longint'(rho), zi <<< (32 - CW))));
        r.azi = 17'(degrees_q8(vector_angle(yi <<< (32 - CW), xi <<< (32 - CW))));
        return r;
    endfunction

    // Record the expected result of every accepted input transaction.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            pending_results.push_back(predict_sphere(x, y, z));
    end

    // Compare every accepted output transaction with the oldest expectation.
    always @(posedge clk)
    begin
        sphere_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: mag %0d pol %0d azi %0d",
                             magnitude, polar_angle, azimuth);
            end
            else
            begin
                e = pending_results.pop_front();
                if (e.mag !== magnitude || e.pol !== polar_angle || e.azi !== azimuth)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected mag %0d pol %0d azi %0d, got %0d %0d %0d",
                                 e.mag, e.pol, e.azi, magnitude, polar_angle, azimuth);
                end
            end
        end
    end

    // Receiver: a long hold-off when requested, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one vector and wait for it to be taken; gaps fall between bursts.
    task automatic send_vector(input logic signed [CW-1:0] a,
                               input logic signed [CW-1:0] b,
                               input logic signed [CW-1:0] c);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(3);
            if (gap > 0 && in_valid)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        x <= a;
        y <= b;
        z <= c;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
        localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
        send_vector(0, 0, 0);
        send_vector(1, 0, 0);
        send_vector(-1, 0, 0);
        send_vector(0, 1, 0);
        send_vector(0, -1, 0);
        send_vector(0, 0, 1);
        send_vector(0, 0, -1);
        send_vector(MINV, 0, 0);
        send_vector(0, MINV, 0);
        send_vector(0, 0, MINV);
        send_vector(MAXV, MAXV, MAXV);
        send_vector(MINV, MINV, MINV);
        send_vector(MAXV, MINV, MAXV);
        send_vector(MINV, MAXV, MINV);
        send_vector(1, 1, 1);
        send_vector(-1, -1, -1);
        send_vector(-5, 3, 0);
        send_vector(-5, -3, 7);
        send_vector(MAXV, 0, MINV);
        send_vector(-1, 0, MAXV);
        send_vector(0, 0, MAXV);
        drain_results();
    endtask

    function automatic logic signed [CW-1:0] pick_coord(input int kind);
        case (kind)
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(0, 64)) - 32);
            2: return 0;
            default: return ($urandom_range(1) != 0)
                            ? CW'({1'b0, {(CW-1){1'b1}}} - $urandom_range(3))
                            : CW'({1'b1, {(CW-1){1'b0}}} + $urandom_range(3));
        endcase
    endfunction

    task automatic test_random(input int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < 60)
                send_vector(pick_coord(0), pick_coord(0), pick_coord(0));
            else
                send_vector(pick_coord($urandom_range(3)), pick_coord($urandom_range(3)),
                            pick_coord($urandom_range(3)));
            // Switch the receiver between stall patterns now and then.
            if (i % 250 == 0)
                stall_pct = (i % 500 == 0) ? 0 : $urandom_range(10, 70);
        end
        drain_results();
    endtask

    // Long receiver hold-off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        hold_request = 300;
        for (int i = 0; i < 150; i++)
            send_vector(pick_coord(0), pick_coord(0), pick_coord(0));
        drain_results();
    endtask

    initial
    begin
        longint unsigned v;
        for (int i = 0; i < STEPS; i++)
        begin
            if (i == 0)
                v = arctan_inv_q62(2) + arctan_inv_q62(3);
            else
                v = arctan_inv_q62(64'd1 << i);
            arctan_q32[i] = longint'((v + (64'd1 << 29)) >> 30);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(2000);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("cartesian_to_spherical_top verification clean");
        else
            $display("cartesian_to_spherical_top verification failed");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #20ms;
        $display("cartesian_to_spherical_top verification failed");
        $finish;
    end

endmodule
